FILE: rtl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int WSIZE_BITS  = 7;
    localparam int AGE_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

    // command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_CLEAR,
        CMD_AGE,
        CMD_SHIFT,
        CMD_INSERT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                      cmd;
        logic signed [SAMPLE_BITS-1:0]  sample;
    } cell_ctrl_t;

    // contents of one cell, handed to the left neighbour on a shift
    typedef struct packed {
        logic                           valid;
        logic signed [SAMPLE_BITS-1:0]  value;
        logic [AGE_BITS-1:0]            age;
    } cell_data_t;

    // zero reads as one, anything above the row length saturates
    function automatic logic [AGE_BITS-1:0] eff_window(input logic [WSIZE_BITS-1:0] w);
        logic [AGE_BITS-1:0] k;
        if (w == '0)
        begin
            k = AGE_BITS'(1);
        end
        else if (int'(w) > WINDOW_MAX)
        begin
            k = AGE_BITS'(WINDOW_MAX);
        end
        else
        begin
            k = AGE_BITS'(w);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/swm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_cell
    import swm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       left_keep,
    input  wire cell_data_t right,
    output cell_data_t      cur,
    output logic            keep
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic [AGE_BITS-1:0]           age_reg;
    logic [AGE_BITS-1:0]           age_next;

    // candidate survives the new sample unless strictly smaller
    assign keep = valid_reg && (value_reg >= ctrl.sample);

    assign cur.valid = valid_reg;
    assign cur.value = value_reg;
    assign cur.age   = age_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        case (ctrl.cmd)
            CMD_CLEAR:
            begin
                valid_next = 1'b0;
            end
            CMD_AGE:
            begin
                if (age_reg < AGE_BITS'(WINDOW_MAX))
                begin
                    age_next = age_reg + AGE_BITS'(1);
                end
            end
            CMD_SHIFT:
            begin
                valid_next = right.valid;
                value_next = right.value;
                age_next   = right.age;
            end
            CMD_INSERT:
            begin
                if (!keep)
                begin
                    // first dropped slot takes the new sample
                    valid_next = left_keep;
                    value_next = ctrl.sample;
                    age_next   = '0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

`default_nettype wire

FILE: rtl/sliding_window_maximum.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata (low bit up)        tuser        notes
// s_axis    in   sample[15:0]              start_req    one transaction per sample
// m_axis    out  window_max[15:0]          -            zero or one per sample
// cfg       in   cfg_wdata: window_size    -            write on cfg_we, idle only
//
// a sample passes through accept and ageing, one insert step through the cell row, then
// a load of the output register; each expired candidate at the head of the row is first
// shifted out by a further shift step (at most one unless the window has just shrunk)
// reset empties the candidate row, clears the sample count and sets the window to one
// the output register lets a new transaction in while a result waits; a second result
// then holds in the final step until m_axis_tready frees the register

module sliding_window_maximum
    import swm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [TDATA_BITS-1:0]  s_axis_tdata,   // sample
    input  wire logic                   s_axis_tuser,   // start_req
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_BITS-1:0]       m_axis_tdata,   // window_max
    input  wire logic                   cfg_we,
    input  wire logic [WSIZE_BITS-1:0]  cfg_wdata       // window_size
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [WSIZE_BITS-1:0]         wsize_reg;
    logic [WSIZE_BITS-1:0]         wsize_next;
    logic [AGE_BITS-1:0]           seen_reg;
    logic [AGE_BITS-1:0]           seen_next;
    logic                          emit_reg;
    logic                          emit_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_data_reg;
    logic signed [SAMPLE_BITS-1:0] m_data_next;

    logic [AGE_BITS-1:0]           win_k;
    logic [AGE_BITS-1:0]           seen_base;
    logic [AGE_BITS-1:0]           seen_clamp;
    logic                          s_accept;
    logic                          front_expired;
    cell_ctrl_t                    row_ctrl;

    // cell i sits at position i of the candidate list; index WINDOW_MAX is the empty tail
    cell_data_t                    cell_data [WINDOW_MAX+1];
    logic [WINDOW_MAX-1:0]         keep_vec;

    assign win_k         = eff_window(wsize_reg);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDATA_BITS'($unsigned(m_data_reg));

    // head candidate too old for the current window
    assign front_expired = cell_data[0].valid && (cell_data[0].age >= win_k);

    assign cell_data[WINDOW_MAX] = '0;

    // row of cells: shift data moves leftwards, keep flags ripple rightwards
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic left_keep;
        if (i == 0)
        begin : g_head
            assign left_keep = 1'b1;
        end
        else
        begin : g_body
            assign left_keep = keep_vec[i-1];
        end
        swm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (row_ctrl),
            .left_keep (left_keep),
            .right     (cell_data[i+1]),
            .cur       (cell_data[i]),
            .keep      (keep_vec[i])
        );
    end

    // command for the row, decoded from the sequencer state
    always_comb
    begin
        row_ctrl.sample = sample_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    // start empties the row, otherwise every candidate grows older
                    row_ctrl.cmd = s_axis_tuser ? CMD_CLEAR : CMD_AGE;
                end
                else
                begin
                    row_ctrl.cmd = CMD_HOLD;
                end
            end
            ST_WORK:
            begin
                row_ctrl.cmd = front_expired ? CMD_SHIFT : CMD_INSERT;
            end
            default:
            begin
                row_ctrl.cmd = CMD_HOLD;
            end
        endcase
    end

    // sample count of the current sequence, clamped to the window then advanced
    always_comb
    begin
        seen_base  = s_axis_tuser ? '0 : seen_reg;
        seen_clamp = (seen_base > win_k) ? win_k : seen_base;
    end

    always_comb
    begin
        state_next   = state_reg;
        wsize_next   = wsize_reg;
        seen_next    = seen_reg;
        emit_next    = emit_reg;
        sample_next  = sample_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            wsize_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    sample_next = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
                    if (seen_clamp < win_k)
                    begin
                        seen_next = seen_clamp + AGE_BITS'(1);
                    end
                    else
                    begin
                        seen_next = seen_clamp;
                    end
                    emit_next  = (seen_clamp + AGE_BITS'(1) >= win_k);
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                // one expired head leaves per cycle, then the sample goes in
                if (!front_expired)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = cell_data[0].value;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wsize_reg   <= WSIZE_BITS'(1);
            seen_reg    <= '0;
            emit_reg    <= 1'b0;
            sample_reg  <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wsize_reg   <= wsize_next;
            seen_reg    <= seen_next;
            emit_reg    <= emit_next;
            sample_reg  <= sample_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    logic [WINDOW_MAX-1:0] valid_vec;
    logic [WINDOW_MAX:0]   valid_inc;

    for (genvar j = 0; j < WINDOW_MAX; j++)
    begin : g_valid
        assign valid_vec[j] = cell_data[j].valid;
    end
    assign valid_inc = {1'b0, valid_vec} + (WINDOW_MAX+1)'(1);

    // candidates always fill a prefix of the row
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(valid_inc))
        else $error("candidate row has a gap");

    // insert never meets a full row
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        (row_ctrl.cmd == CMD_INSERT) |-> !keep_vec[WINDOW_MAX-1])
        else $error("candidate row overflow");

    // after the insert step the head is present and inside the window
    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cell_data[0].valid && (cell_data[0].age < win_k)))
        else $error("head candidate missing or stale");

    // a result appears only out of the final step
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg == ST_EMIT) && $past(emit_reg)))
        else $error("result loaded outside final step");
`endif

endmodule

`default_nettype wire
